// ----- hdl/bwlm_pkg.sv -----
// Shared constants and widths for the busy/idle window load monitor.
`timescale 1ns / 1ps

package bwlm_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int IDX_W       = $clog2(MAX_RECORDS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int DUR_W       = 32;
    localparam int REC_W       = DUR_W + 1;
    // 65 durations of at most 2^32-1 each stay below 2^39
    localparam int SUM_W       = DUR_W + 7;
    // busy * 100 stays below 2^46
    localparam int NUM_W       = SUM_W + 7;
    localparam int Q_W         = 7;
    localparam int BIT_W       = 3;
    localparam int FUNC_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int CAP_W       = 7;

    localparam logic [FUNC_W-1:0] FUNC_SLEEP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WAKE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECORDS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_US   = 2'd1;

    localparam logic [CAP_W-1:0] MAX_RECORDS_RST = CAP_W'(64);
    localparam logic [DUR_W-1:0] WINDOW_US_RST   = DUR_W'(1000000);

endpackage

// ----- hdl/busy_idle_window_load_monitor.sv -----
// Top level of the busy/idle sliding-window load monitor.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+---------------------------
// in       | input     | in_valid / in_ready  | func, now_us
// out      | output    | out_valid / out_ready| load_percent
// cfg      | input     | cfg_we (no wait)     | cfg_index, cfg_data
//
// Sleep and wake events pass through S_EVT, and S_WRITE when a record is stored;
// ignored codes are dropped. A query runs S_OPEN, then S_SUM over the N stored
// records on the single record memory port, S_TOT and S_CHK once and again per
// each of the E evictions, then S_MUL1, S_MUL2, S_DIV and S_DONE on the shared adder.
// Reset clears the ring pointers and flags; the record memory is not cleared,
// only slots below the record count are ever used.
// in_ready is low while an item is at work; a finished result waits in the
// output register and holds off the next query's completion until taken.

module busy_idle_window_load_monitor (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bwlm_pkg::FUNC_W-1:0]         func,
    input  logic [bwlm_pkg::DUR_W-1:0]          now_us,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bwlm_pkg::Q_W-1:0]            load_percent,
    input  logic                                cfg_we,
    input  logic [bwlm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bwlm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE  = 4'd0;
    localparam logic [ST_W-1:0] S_EVT   = 4'd1;
    localparam logic [ST_W-1:0] S_WRITE = 4'd2;
    localparam logic [ST_W-1:0] S_OPEN  = 4'd3;
    localparam logic [ST_W-1:0] S_SUM   = 4'd4;
    localparam logic [ST_W-1:0] S_TOT   = 4'd5;
    localparam logic [ST_W-1:0] S_CHK   = 4'd6;
    localparam logic [ST_W-1:0] S_MUL1  = 4'd7;
    localparam logic [ST_W-1:0] S_MUL2  = 4'd8;
    localparam logic [ST_W-1:0] S_DIV   = 4'd9;
    localparam logic [ST_W-1:0] S_DONE  = 4'd10;

    localparam int IDX_W = bwlm_pkg::IDX_W;
    localparam int CNT_W = bwlm_pkg::CNT_W;
    localparam int DUR_W = bwlm_pkg::DUR_W;
    localparam int SUM_W = bwlm_pkg::SUM_W;
    localparam int NUM_W = bwlm_pkg::NUM_W;
    localparam int Q_W   = bwlm_pkg::Q_W;
    localparam int BIT_W = bwlm_pkg::BIT_W;
    localparam int CAP_W = bwlm_pkg::CAP_W;

    // Configuration registers
    logic [CAP_W-1:0]               max_records_reg;
    logic [DUR_W-1:0]               window_us_reg;

    // Sequencer and architectural state
    logic [ST_W-1:0]                state_reg, state_next;
    logic [IDX_W-1:0]               oldest_reg, oldest_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic                           sleeping_reg, sleeping_next;
    logic [DUR_W-1:0]               last_wake_reg, last_wake_next;
    logic [DUR_W-1:0]               last_sleep_reg, last_sleep_next;

    // Per-item working registers
    logic [bwlm_pkg::FUNC_W-1:0]    func_reg;
    logic [DUR_W-1:0]               now_reg;
    logic [DUR_W-1:0]               dur_reg, dur_next;
    logic [SUM_W-1:0]               busy_reg, busy_next;
    logic [SUM_W-1:0]               idle_reg, idle_next;
    logic [SUM_W-1:0]               total_reg, total_next;
    logic [NUM_W-1:0]               rem_reg, rem_next;
    logic [Q_W-1:0]                 quo_reg, quo_next;
    logic [BIT_W-1:0]               bit_reg, bit_next;
    logic [CNT_W-1:0]               k_reg, k_next;
    logic                           rd_pend_reg;

    // Output register
    logic                           out_valid_reg, out_valid_next;
    logic [Q_W-1:0]                 load_reg, load_next;

    // Record memory
    logic [bwlm_pkg::REC_W-1:0]     rec_mem [bwlm_pkg::MAX_RECORDS];
    logic [bwlm_pkg::REC_W-1:0]     rd_data_reg;
    logic                           rd_en;
    logic [IDX_W-1:0]               rd_addr;
    logic                           wr_en;
    logic [IDX_W-1:0]               wr_addr;

    // Shared adder
    logic [NUM_W-1:0]               alu_a, alu_b, alu_res;
    logic                           alu_sub, alu_carry;

    logic [CNT_W-1:0]               cap_eff;
    logic                           accept;
    logic                           rec_idle;
    logic [DUR_W-1:0]               rec_dur;
    logic [NUM_W-1:0]               busy_ext, idle_ext, total_ext, dur_ext;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign load_percent = load_reg;

    assign rec_idle  = rd_data_reg[DUR_W];
    assign rec_dur   = rd_data_reg[DUR_W-1:0];
    assign busy_ext  = NUM_W'(busy_reg);
    assign idle_ext  = NUM_W'(idle_reg);
    assign total_ext = NUM_W'(total_reg);
    assign dur_ext   = NUM_W'(rec_dur);

    // Clamp the record cap into 1..MAX_RECORDS
    always_comb
    begin
        if (max_records_reg == '0)
            cap_eff = CNT_W'(1);
        else if (CNT_W'(max_records_reg) > CNT_W'(bwlm_pkg::MAX_RECORDS))
            cap_eff = CNT_W'(bwlm_pkg::MAX_RECORDS);
        else
            cap_eff = CNT_W'(max_records_reg);
    end

    // Operand selection for the shared adder
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            S_EVT, S_OPEN:
            begin
                // open-interval length, modulo 2^32
                alu_a   = NUM_W'(now_reg);
                alu_b   = NUM_W'(sleeping_reg ? last_sleep_reg : last_wake_reg);
                alu_sub = 1'b1;
            end
            S_SUM:
            begin
                alu_a = rec_idle ? idle_ext : busy_ext;
                alu_b = dur_ext;
            end
            S_TOT:
            begin
                alu_a = busy_ext;
                alu_b = idle_ext;
            end
            S_CHK:
            begin
                alu_a   = rec_idle ? idle_ext : busy_ext;
                alu_b   = dur_ext;
                alu_sub = 1'b1;
            end
            S_MUL1:
            begin
                alu_a = busy_ext << 6;
                alu_b = busy_ext << 5;
            end
            S_MUL2:
            begin
                alu_a = rem_reg;
                alu_b = busy_ext << 2;
            end
            S_DIV:
            begin
                alu_a   = rem_reg;
                alu_b   = total_ext << bit_reg;
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    bwlm_alu u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .sub    (alu_sub),
        .result (alu_res),
        .carry  (alu_carry)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        oldest_next     = oldest_reg;
        count_next      = count_reg;
        sleeping_next   = sleeping_reg;
        last_wake_next  = last_wake_reg;
        last_sleep_next = last_sleep_reg;
        dur_next        = dur_reg;
        busy_next       = busy_reg;
        idle_next       = idle_reg;
        total_next      = total_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        bit_next        = bit_reg;
        k_next          = k_reg;
        out_valid_next  = out_valid_reg;
        load_next       = load_reg;
        rd_en           = 1'b0;
        rd_addr         = oldest_reg;
        wr_en           = 1'b0;
        wr_addr         = oldest_reg + count_reg[IDX_W-1:0];

        // drop the result once taken
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (func == bwlm_pkg::FUNC_QUERY)
                        state_next = S_OPEN;
                    else if (func == bwlm_pkg::FUNC_SLEEP || func == bwlm_pkg::FUNC_WAKE)
                        state_next = S_EVT;
                end
            end
            S_EVT:
            begin
                state_next = S_IDLE;
                if (func_reg == bwlm_pkg::FUNC_SLEEP)
                begin
                    sleeping_next   = 1'b1;
                    last_sleep_next = now_reg;
                end
                else
                begin
                    sleeping_next  = 1'b0;
                    last_wake_next = now_reg;
                end
                // a state change closes the open interval into a record
                if ((func_reg == bwlm_pkg::FUNC_SLEEP) != sleeping_reg)
                begin
                    dur_next   = alu_res[DUR_W-1:0];
                    state_next = S_WRITE;
                    // trim the ring so the new record fits under the cap
                    if (count_reg >= cap_eff)
                    begin
                        oldest_next = oldest_reg + IDX_W'(count_reg - cap_eff + CNT_W'(1));
                        count_next  = cap_eff - CNT_W'(1);
                    end
                end
            end
            S_WRITE:
            begin
                wr_en      = 1'b1;
                count_next = count_reg + CNT_W'(1);
                state_next = S_IDLE;
            end
            S_OPEN:
            begin
                if (sleeping_reg)
                begin
                    idle_next = SUM_W'(alu_res[DUR_W-1:0]);
                    busy_next = '0;
                end
                else
                begin
                    busy_next = SUM_W'(alu_res[DUR_W-1:0]);
                    idle_next = '0;
                end
                k_next     = '0;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                // issue one read a cycle, add the previous one
                if (k_reg < count_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = oldest_reg + k_reg[IDX_W-1:0];
                    k_next  = k_reg + CNT_W'(1);
                end
                if (rd_pend_reg)
                begin
                    if (rec_idle)
                        idle_next = alu_res[SUM_W-1:0];
                    else
                        busy_next = alu_res[SUM_W-1:0];
                end
                else if (k_reg >= count_reg)
                    state_next = S_TOT;
            end
            S_TOT:
            begin
                total_next = alu_res[SUM_W-1:0];
                rd_en      = 1'b1;
                rd_addr    = oldest_reg;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (total_reg > SUM_W'(window_us_reg) && count_reg != '0)
                begin
                    // evict the oldest record
                    if (rec_idle)
                        idle_next = alu_res[SUM_W-1:0];
                    else
                        busy_next = alu_res[SUM_W-1:0];
                    oldest_next = oldest_reg + IDX_W'(1);
                    count_next  = count_reg - CNT_W'(1);
                    state_next  = S_TOT;
                end
                else
                    state_next = S_MUL1;
            end
            S_MUL1:
            begin
                rem_next   = alu_res;
                quo_next   = '0;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                rem_next   = alu_res;
                bit_next   = BIT_W'(Q_W - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // restoring division, one quotient bit a cycle
                if (alu_carry)
                begin
                    rem_next          = alu_res;
                    quo_next[bit_reg] = 1'b1;
                end
                bit_next = bit_reg - BIT_W'(1);
                if (bit_reg == '0)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    load_next      = (total_reg == '0) ? '0 : quo_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            oldest_reg      <= '0;
            count_reg       <= '0;
            sleeping_reg    <= 1'b0;
            last_wake_reg   <= '0;
            last_sleep_reg  <= '0;
            out_valid_reg   <= 1'b0;
            rd_pend_reg     <= 1'b0;
            max_records_reg <= bwlm_pkg::MAX_RECORDS_RST;
            window_us_reg   <= bwlm_pkg::WINDOW_US_RST;
        end
        else
        begin
            state_reg      <= state_next;
            oldest_reg     <= oldest_next;
            count_reg      <= count_next;
            sleeping_reg   <= sleeping_next;
            last_wake_reg  <= last_wake_next;
            last_sleep_reg <= last_sleep_next;
            out_valid_reg  <= out_valid_next;
            rd_pend_reg    <= (state_reg == S_SUM) && (k_reg < count_reg);
            if (cfg_we)
            begin
                if (cfg_index == bwlm_pkg::CFG_MAX_RECORDS)
                    max_records_reg <= cfg_data[CAP_W-1:0];
                else if (cfg_index == bwlm_pkg::CFG_WINDOW_US)
                    window_us_reg <= cfg_data[DUR_W-1:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            now_reg  <= now_us;
        end
        dur_reg   <= dur_next;
        busy_reg  <= busy_next;
        idle_reg  <= idle_next;
        total_reg <= total_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        bit_reg   <= bit_next;
        k_reg     <= k_next;
        load_reg  <= load_next;
    end

    // Record memory: idle flag above a 32-bit duration
    always_ff @(posedge clk)
    begin
        if (wr_en)
            rec_mem[wr_addr] <= {(func_reg == bwlm_pkg::FUNC_WAKE), dur_reg};
        if (rd_en)
            rd_data_reg <= rec_mem[rd_addr];
    end

endmodule

// ----- hdl/bwlm_alu.sv -----
// Shared add/subtract unit with carry out, used for interval lengths, sums, evictions, multiply and division.
`timescale 1ns / 1ps

module bwlm_alu (
    input  logic [bwlm_pkg::NUM_W-1:0] a,
    input  logic [bwlm_pkg::NUM_W-1:0] b,
    input  logic                       sub,
    output logic [bwlm_pkg::NUM_W-1:0] result,
    output logic                       carry
);

    logic [bwlm_pkg::NUM_W-1:0] b_in;

    // carry set on a subtract means a >= b
    assign b_in = sub ? ~b : b;
    assign {carry, result} = {1'b0, a} + {1'b0, b_in} + {{bwlm_pkg::NUM_W{1'b0}}, sub};

endmodule
